### rtl/bounded_fifo_with_waiters_core_defines.svh
// assertion macros used by the rtl datapath
`ifndef BOUNDED_FIFO_WITH_WAITERS_CORE_DEFINES_SVH
`define BOUNDED_FIFO_WITH_WAITERS_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFWW_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bfww check failed");

// next-cycle implication, checked out of reset
`define BFWW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bfww check failed");

`endif

### rtl/bfww_pkg.sv
`default_nettype none

package bfww_pkg;

    // default sizes
    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int KIND_W = 2;
    localparam int WORD_W = 32;
    localparam int CAP_W  = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_WAIT = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2
    } cmd_code_t;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DELIVER = 2'd0,
        KIND_GRANT   = 2'd1,
        KIND_DROP    = 2'd2
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic push_wr;      // append input word to store
        logic pop_rd;       // read oldest word, advance read side
        logic load_grant;   // result: space granted
        logic load_drop;    // result: push dropped
        logic load_direct;  // result: input word to parked reader
        logic load_mem;     // result: word read from store
        logic park_writer;
        logic park_reader;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic wait_ok;
        logic reader_parked;
        logic grant_pend;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/bfww_ctrl.sv
`default_nettype none

module bfww_ctrl
    import bfww_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [CMD_W-1:0] s_cmd,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire dp_stat_t         stat,
    output ctrl_cmd_t             cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    cmd_code_t cmd_code;

    assign cmd_code = cmd_code_t'(s_cmd);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    // next state and datapath commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (cmd_code)
                        CMD_WAIT: begin
                            if (stat.wait_ok) begin
                                cmd.load_grant = 1'b1;
                                state_next     = ST_OUT;
                            end else begin
                                cmd.park_writer = 1'b1;
                            end
                        end
                        CMD_PUSH: begin
                            if (stat.empty && stat.reader_parked) begin
                                cmd.load_direct = 1'b1;
                                state_next      = ST_OUT;
                            end else if (stat.full) begin
                                cmd.load_drop = 1'b1;
                                state_next    = ST_OUT;
                            end else begin
                                cmd.push_wr = 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (!stat.empty) begin
                                cmd.pop_rd = 1'b1;
                                state_next = ST_READ;
                            end else begin
                                cmd.park_reader = 1'b1;
                            end
                        end
                        default: begin
                            // unused command, no effect
                        end
                    endcase
                end
            end
            ST_READ: begin
                cmd.load_mem = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (stat.grant_pend) begin
                        cmd.load_grant = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/bfww_datapath.sv
`default_nettype none
`include "bounded_fifo_with_waiters_core_defines.svh"

module bfww_datapath
    import bfww_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_wdata,
    input  wire logic [WORD_W-1:0] in_word,
    input  wire ctrl_cmd_t         cmd,
    output dp_stat_t               stat,
    output logic [KIND_W-1:0]      out_kind,
    output logic [WORD_W-1:0]      out_data,
    output logic                   out_last
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KW    = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CAP_W-1:0] cap_reg;
    logic             writer_parked_reg, writer_parked_next;
    logic             reader_parked_reg, reader_parked_next;
    logic             grant_pend_reg, grant_pend_next;

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;

    logic [DATA_WIDTH-1:0] store_word;

    assign store_word = DATA_WIDTH'(in_word[KW-1:0]);

    // status toward the controller
    assign stat.empty         = (fill_reg == '0);
    assign stat.full          = (fill_reg == CNT_W'(DEPTH));
    assign stat.wait_ok       = (CMP_W'(fill_reg) < CMP_W'(cap_reg));
    assign stat.reader_parked = reader_parked_reg;
    assign stat.grant_pend    = grant_pend_reg;

    assign out_kind = kind_reg;
    assign out_data = data_reg;
    assign out_last = last_reg;

    // word store, registered read
    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            mem[wr_ptr_reg] <= store_word;
        end
        if (cmd.pop_rd) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // pointers and fill level
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (cmd.push_wr) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end else if (cmd.pop_rd) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    // parked flags and pending grant
    always_comb begin
        writer_parked_next = writer_parked_reg;
        reader_parked_next = reader_parked_reg;
        grant_pend_next    = grant_pend_reg;
        if (cmd.park_writer) begin
            writer_parked_next = 1'b1;
        end
        if (cmd.park_reader) begin
            reader_parked_next = 1'b1;
        end
        if (cmd.load_direct) begin
            reader_parked_next = 1'b0;
        end
        if (cmd.load_mem) begin
            writer_parked_next = 1'b0;
            grant_pend_next    = writer_parked_reg;
        end
        if (cmd.load_grant) begin
            grant_pend_next = 1'b0;
        end
    end

    // result register
    always_comb begin
        kind_next = kind_reg;
        data_next = data_reg;
        last_next = last_reg;
        priority if (cmd.load_grant) begin
            kind_next = KIND_GRANT;
            data_next = '0;
            last_next = 1'b1;
        end else if (cmd.load_drop) begin
            kind_next = KIND_DROP;
            data_next = '0;
            last_next = 1'b1;
        end else if (cmd.load_direct) begin
            kind_next = KIND_DELIVER;
            data_next = WORD_W'(store_word[KW-1:0]);
            last_next = 1'b1;
        end else if (cmd.load_mem) begin
            kind_next = KIND_DELIVER;
            data_next = WORD_W'(rd_data_reg[KW-1:0]);
            last_next = !writer_parked_reg;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg        <= '0;
            wr_ptr_reg        <= '0;
            fill_reg          <= '0;
            cap_reg           <= CAP_RESET;
            writer_parked_reg <= 1'b0;
            reader_parked_reg <= 1'b0;
            grant_pend_reg    <= 1'b0;
        end else begin
            rd_ptr_reg        <= rd_ptr_next;
            wr_ptr_reg        <= wr_ptr_next;
            fill_reg          <= fill_next;
            writer_parked_reg <= writer_parked_next;
            reader_parked_reg <= reader_parked_next;
            grant_pend_reg    <= grant_pend_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // checks
    `BFWW_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= CNT_W'(DEPTH))
    `BFWW_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, cmd.pop_rd, fill_reg != '0)
    `BFWW_ASSERT_NOW(a_no_push_full, aclk, aresetn, cmd.push_wr, fill_reg != CNT_W'(DEPTH))
    `BFWW_ASSERT_NEXT(a_grant_follows, aclk, aresetn, cmd.load_mem && writer_parked_reg, grant_pend_reg && !last_reg)

endmodule

`default_nettype wire

### rtl/bounded_fifo_with_waiters_core.sv
`default_nettype none

// Bounded FIFO with one parked writer and one parked reader. Each input word carries a
// command in s_tuser (wait for space, push, pop) and a data word in s_tdata; results
// come out as kind in m_tuser, the word in m_tdata and tlast on the final result of a
// command. The block works on one command at a time: s_tready is high only when it is
// idle. A wait or a pop that parks, and a push that stores its word, give no result and
// leave the block idle; a command with a single result is held in the output register
// until taken, then the block is idle again. A pop that finds data reads the store into
// a read register, then loads the result; a second result (space granted) follows when
// a writer was parked. The user writes the capacity register via cfg_we/cfg_wdata only
// while idle; the block does not enforce it. The store needs no clearing after reset.
module bounded_fifo_with_waiters_core
    import bfww_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // capacity register
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_wdata,
    // command channel
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [WORD_W-1:0] s_tdata,   // data_in
    input  wire logic [CMD_W-1:0]  s_tuser,   // command
    // result channel
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [WORD_W-1:0]      m_tdata,   // data_out
    output logic [KIND_W-1:0]      m_tuser,   // kind
    output logic                   m_tlast
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer
    bfww_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, pointers and result register
    bfww_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_word   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_kind  (m_tuser),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire
